### design/upe_pkg.sv
// Shared types, codes and a helper function of the URL percent-encoder.
package upe_pkg;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_MASK_LOW    = 3'd0;
  localparam logic [2:0] REG_MASK_HIGH   = 3'd1;
  localparam logic [2:0] REG_ALREADY_ENC = 3'd2;
  localparam logic [2:0] REG_STRICT_ESC  = 3'd3;
  localparam logic [2:0] REG_PLUS_SPACE  = 3'd4;
  localparam logic [2:0] REG_ASCII_ONLY  = 3'd5;

  // How one input byte is rendered.
  localparam logic [1:0] KIND_COPY = 2'd0;
  localparam logic [1:0] KIND_HEX  = 2'd1;
  localparam logic [1:0] KIND_P2B  = 2'd2;
  localparam logic [1:0] KIND_DROP = 2'd3;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_TWO     = 8'h32;
  localparam logic [7:0] CH_LOW_B   = 8'h62;

  typedef struct packed {
    logic [127:0] mask;
    logic         already;
    logic         strict;
    logic         plus;
    logic         ascii;
  } upe_cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
  } upe_slot_t;

  // One decided step: up to three kept bytes, packed from slot 0 upward.
  typedef struct packed {
    upe_slot_t [2:0] slot;
    logic [1:0]      count;
    logic            last;
  } upe_entry_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h37 + {4'd0, nib};
    end
    return c;
  endfunction

endpackage

### design/upe_front.sv
// Front end: accepts bytes, keeps the two-byte lookahead window and classifies them.
module upe_front import upe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  upe_cfg_t   cfg,
  input  logic       in_push,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_string,
  input  logic       q_full,
  output logic       q_push,
  output upe_entry_t q_entry
);

  logic [7:0] held0_r, held1_r;
  logic [1:0] held_count_r;
  logic       accept;
  logic       win_full;
  logic [7:0] seq [3];
  logic       esc0;
  logic [1:0] raw_n;
  logic [1:0] kind [3];

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [1:0] classify(input logic [7:0] b, input logic esc_ok,
                                          input upe_cfg_t c);
    logic       ws;
    logic       enc;
    logic [1:0] k;
    ws  = (b == 8'h09) || (b == 8'h0a) || (b == 8'h0c) || (b == 8'h0d);
    enc = (b < 8'h20) || (b == 8'h7f) || (b[7] && c.ascii) ||
          (!b[7] && c.mask[b[6:0]]) ||
          ((b == CH_PERCENT) && (!c.already || (c.strict && !esc_ok)));
    priority if (c.already && ws) begin
      k = KIND_DROP;
    end else if ((b == CH_PLUS) && c.plus) begin
      k = c.already ? KIND_COPY : KIND_P2B;
    end else if (enc) begin
      k = KIND_HEX;
    end else begin
      k = KIND_COPY;
    end
    return k;
  endfunction

  assign win_full = held_count_r[1];
  assign accept   = in_push && !q_full;
  // A mid-string step whose only byte is dropped has nothing to send.
  assign q_push   = accept &&
                    (in_end_of_string || (win_full && (q_entry.count != 2'd0)));

  // Bytes in string order: held bytes first, then the new one.
  always_comb begin
    seq[0] = (held_count_r == 2'd0) ? in_byte : held0_r;
    seq[1] = win_full ? held1_r : in_byte;
    seq[2] = in_byte;
    // Only the oldest byte of a full window sees two bytes ahead.
    esc0   = win_full && is_hex(seq[1]) && is_hex(seq[2]);
    if (in_end_of_string) begin
      raw_n = win_full ? 2'd3 : held_count_r + 2'd1;
    end else begin
      raw_n = win_full ? 2'd1 : 2'd0;
    end
    kind[0] = classify(seq[0], esc0, cfg);
    kind[1] = classify(seq[1], 1'b0, cfg);
    kind[2] = classify(seq[2], 1'b0, cfg);
  end

  // Pack the kept bytes so the back end never sees a dropped one.
  always_comb begin
    logic [1:0] pos;
    pos = 2'd0;
    q_entry = '0;
    q_entry.last = in_end_of_string;
    for (int i = 0; i < 3; i++) begin
      if ((2'(i) < raw_n) && (kind[i] != KIND_DROP)) begin
        q_entry.slot[pos].data = seq[i];
        q_entry.slot[pos].kind = kind[i];
        pos = pos + 2'd1;
      end
    end
    q_entry.count = pos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_count_r <= 2'd0;
    end else if (accept) begin
      if (in_end_of_string) begin
        held_count_r <= 2'd0;
      end else if (!win_full) begin
        held_count_r <= held_count_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !in_end_of_string) begin
      if (win_full) begin
        held0_r <= held1_r;
        held1_r <= in_byte;
      end else if (held_count_r == 2'd0) begin
        held0_r <= in_byte;
      end else begin
        held1_r <= in_byte;
      end
    end
  end

endmodule

### design/upe_queue.sv
// Short queue of decided steps between the front and back ends.
module upe_queue import upe_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  upe_entry_t push_entry,
  input  logic       pop,
  output upe_entry_t head,
  output logic       q_empty,
  output logic       q_full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  upe_entry_t      store_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;

  assign q_empty = (count_r == '0);
  assign q_full  = (count_r == CW'(DEPTH));
  assign head    = store_r[rd_ptr_r];

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= next_ptr(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= next_ptr(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

### design/upe_back.sv
// Back end: expands decided bytes into output beats, one beat per cycle while beats are popped.
module upe_back import upe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  upe_entry_t head,
  input  logic       q_empty,
  output logic       q_pop,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       out_end
);

  logic       ovld_r;
  logic [7:0] obyte_r;
  logic       ovalid_r, oend_r;
  logic [1:0] slot_r, phase_r;
  logic       can_load, step, marker, slot_done, entry_done;
  upe_slot_t  cur;
  logic [7:0] byte_nxt;

  assign can_load = !ovld_r || pop;
  assign step     = !q_empty && can_load;
  assign cur      = head.slot[slot_r];
  assign marker   = (head.count == 2'd0);

  always_comb begin
    byte_nxt  = cur.data;
    slot_done = 1'b1;
    unique case (cur.kind)
      KIND_HEX: begin
        slot_done = (phase_r == 2'd2);
        unique case (phase_r)
          2'd0:    byte_nxt = CH_PERCENT;
          2'd1:    byte_nxt = hex_char(cur.data[7:4]);
          default: byte_nxt = hex_char(cur.data[3:0]);
        endcase
      end
      KIND_P2B: begin
        slot_done = (phase_r == 2'd2);
        unique case (phase_r)
          2'd0:    byte_nxt = CH_PERCENT;
          2'd1:    byte_nxt = CH_TWO;
          default: byte_nxt = CH_LOW_B;
        endcase
      end
      default: begin
        byte_nxt  = cur.data;
        slot_done = 1'b1;
      end
    endcase
  end

  assign entry_done = marker || (slot_done && (slot_r == head.count - 2'd1));
  assign q_pop      = step && entry_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r  <= 1'b0;
      slot_r  <= 2'd0;
      phase_r <= 2'd0;
    end else if (step) begin
      ovld_r <= 1'b1;
      if (entry_done) begin
        slot_r  <= 2'd0;
        phase_r <= 2'd0;
      end else if (slot_done) begin
        slot_r  <= slot_r + 2'd1;
        phase_r <= 2'd0;
      end else begin
        phase_r <= phase_r + 2'd1;
      end
    end else if (pop) begin
      ovld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (marker) begin
        obyte_r  <= 8'h00;
        ovalid_r <= 1'b0;
        oend_r   <= 1'b1;
      end else begin
        obyte_r  <= byte_nxt;
        ovalid_r <= 1'b1;
        oend_r   <= head.last && entry_done;
      end
    end
  end

  assign empty     = !ovld_r;
  assign out_byte  = obyte_r;
  assign out_valid = ovalid_r;
  assign out_end   = oend_r;

endmodule

### design/url_percent_encoder_unit.sv
// Top level of the streaming URL percent-encoder with its configuration registers.
// The byte completing a step is written into the step queue; the back end then loads the
// step's first beat from the queue head into the output register once that one is free.
// The front takes one byte per cycle while the queue is not full; the back end sends one
// beat per cycle while beats are popped, a byte giving one beat copied, three escaped (%HH or %2b).
// Reset (synchronous, rst_n low) empties the window, the queue and the output register
// and clears every configuration register to zero.
module url_percent_encoder_unit import upe_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [63:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_string,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_valid,
  output logic        out_end
);

  // The configuration registers. They are to be written only while the block is idle, which
  // the block itself does not enforce, so the front end may read them without any hand-off.
  upe_cfg_t   cfg_r;

  upe_entry_t push_entry;
  upe_entry_t head;
  logic       q_push, q_pop, q_empty, q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_MASK_LOW:    cfg_r.mask[63:0]   <= cfg_data;
        REG_MASK_HIGH:   cfg_r.mask[127:64] <= cfg_data;
        REG_ALREADY_ENC: cfg_r.already      <= cfg_data[0];
        REG_STRICT_ESC:  cfg_r.strict       <= cfg_data[0];
        REG_PLUS_SPACE:  cfg_r.plus         <= cfg_data[0];
        REG_ASCII_ONLY:  cfg_r.ascii        <= cfg_data[0];
        default: begin
          // Writes to unused indexes are ignored.
        end
      endcase
    end
  end

  // The front end holds up to two bytes of lookahead. Every accepted byte that fills
  // a full window and keeps a byte, and every byte with the end mark, yields one step
  // entry carrying the bytes decided by it, with dropped bytes already squeezed out.
  upe_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_push          (push),
    .in_byte          (in_byte),
    .in_end_of_string (in_end_of_string),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_entry          (push_entry)
  );

  // The queue lets the front keep taking bytes while the back end is busy
  // expanding escapes or the consumer is stalled.
  upe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head       (head),
    .q_empty    (q_empty),
    .q_full     (q_full)
  );

  // The back end walks each entry slot by slot and phase by phase. An entry that
  // closes a string but kept no byte becomes the empty end marker beat.
  upe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .pop       (pop),
    .empty     (empty),
    .out_byte  (out_byte),
    .out_valid (out_valid),
    .out_end   (out_end)
  );

  assign full = q_full;

endmodule

### design/upe_checker.sv
// Port-level checker for the URL percent-encoder and its bind to the top level.
module upe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       out_valid,
  input logic       out_end
);

  // Reset leaves no beat waiting and room for input.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> (empty && !full))
    else $error("block not idle after reset");

  // A beat that is not taken stays as it is.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_valid) &&
                          $stable(out_end)))
    else $error("waiting beat changed");

  // A beat without a byte is only the empty end marker.
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_valid) |-> (out_end && (out_byte == 8'h00)))
    else $error("malformed empty end marker");

  // The queue only fills up on an incoming byte.
  a_full_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(full) |-> $past(push))
    else $error("full rose without input");

endmodule

bind url_percent_encoder_unit upe_checker u_upe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .push      (push),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .out_byte  (out_byte),
  .out_valid (out_valid),
  .out_end   (out_end)
);

### tb/url_percent_encoder_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the streaming URL percent-encoder unit, with its own predictor.
module url_percent_encoder_unit_tb;
  import upe_pkg::*;

  // Indexes that no register answers to; writes there must change nothing.
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  // Characters the rules single out beyond those the package already names.
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_HIGH  = 8'h80;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 8;
  localparam int SEGMENTS        = 6;
  localparam int SEGMENT_BYTES   = 50;
  localparam int RUN_LIMIT_NS    = 2_000_000;

  // One raw byte waiting to be offered, and one canonical beat waiting to be seen.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } raw_byte_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } canon_beat_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [63:0] cfg_data;
  logic        push;
  logic        full;
  logic [7:0]  in_byte;
  logic        in_end_of_string;
  logic        empty;
  logic        pop;
  logic [7:0]  out_byte;
  logic        out_valid;
  logic        out_end;

  url_percent_encoder_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_idx          (cfg_idx),
    .cfg_data         (cfg_data),
    .push             (push),
    .full             (full),
    .in_byte          (in_byte),
    .in_end_of_string (in_end_of_string),
    .empty            (empty),
    .pop              (pop),
    .out_byte         (out_byte),
    .out_valid        (out_valid),
    .out_end          (out_end)
  );

  // Bytes not yet offered to the block, and canonical beats not yet returned by it.
  raw_byte_t   byte_feed_q[$];
  canon_beat_t canon_q[$];

  // The predictor's copy of the configuration registers.
  logic [63:0] m_mask_lo;
  logic [63:0] m_mask_hi;
  logic        m_already;
  logic        m_strict;
  logic        m_plus;
  logic        m_ascii;

  // The predictor's lookahead window: bytes seen but not yet decided.
  logic [7:0] win [0:1];
  int         win_cnt;

  // Idling knobs, in percent of cycles, plus the long receiver hold-off.
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_off;

  // Set at each rising edge when an input beat was taken, read by the feeder.
  bit in_beat_seen;
  int mismatch_count;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Guard against a hung run, for instance a beat that never comes out.
  initial begin
    #(RUN_LIMIT_NS);
    $display("url_percent_encoder_unit_tb failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatch_count++;
    $display("%0t: %s mismatch: got 0x%02h, want 0x%02h", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Predictor. Every byte is decided once its two followers are known, or when
  // the end mark of its string arrives, whichever comes first.
  // ---------------------------------------------------------------------------

  function automatic bit is_hex_digit(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    return (n < 4'd10) ? ("0" + {4'd0, n}) : ("A" + {4'd0, n} - 8'd10);
  endfunction

  // The 128-bit mask only covers ASCII; bytes with the top bit set never hit it.
  function automatic bit mask_hit(input logic [7:0] b);
    if (b[7]) begin
      return 1'b0;
    end
    return b[6] ? m_mask_hi[b[5:0]] : m_mask_lo[b[5:0]];
  endfunction

  function automatic void put_beat(input logic [7:0] d);
    canon_beat_t beat;
    beat = '{data: d, valid: 1'b1, last: 1'b0};
    canon_q = {canon_q, beat};
  endfunction

  // Decides one byte given the bytes after it (avail of them are real) and
  // queues its canonical beats. Returns how many beats it queued.
  function automatic int canon_one(input logic [7:0] b, input logic [7:0] nx0,
                                   input logic [7:0] nx1, input int avail);
    bit escape_ok;
    escape_ok = avail >= 2 && is_hex_digit(nx0) && is_hex_digit(nx1);
    if (m_already && (b == CH_TAB || b == CH_LF || b == CH_FF || b == CH_CR)) begin
      return 0;
    end
    if (b == CH_PLUS && m_plus) begin
      if (m_already) begin
        put_beat(CH_PLUS);
        return 1;
      end
      put_beat(CH_PERCENT);
      put_beat(CH_TWO);
      put_beat(CH_LOW_B);
      return 3;
    end
    if (b < CH_SPACE || b == CH_DEL || (b >= CH_HIGH && m_ascii) || mask_hit(b) ||
        (b == CH_PERCENT && (!m_already || (m_strict && !escape_ok)))) begin
      put_beat(CH_PERCENT);
      put_beat(hex_digit(b[7:4]));
      put_beat(hex_digit(b[3:0]));
      return 3;
    end
    put_beat(b);
    return 1;
  endfunction

  // Advances the predictor by one accepted input byte.
  function automatic void canon_step(input logic [7:0] b, input logic last);
    logic [7:0]  seq [0:4];
    int          len;
    int          n;
    canon_beat_t tail;
    n = 0;
    if (!last) begin
      if (win_cnt < 2) begin
        win[win_cnt] = b;
        win_cnt++;
      end else begin
        void'(canon_one(win[0], win[1], b, 2));
        win[0] = win[1];
        win[1] = b;
      end
    end else begin
      // The end mark flushes the window; a byte near the end sees fewer followers.
      for (int i = 0; i < 5; i++) begin
        seq[i] = 8'h00;
      end
      for (int i = 0; i < win_cnt; i++) begin
        seq[i] = win[i];
      end
      seq[win_cnt] = b;
      len = win_cnt + 1;
      for (int i = 0; i < len; i++) begin
        n += canon_one(seq[i], seq[i + 1], seq[i + 2], len - 1 - i);
      end
      win_cnt = 0;
      if (n == 0) begin
        // Everything was dropped: a lone end marker carries no byte.
        tail = '{data: 8'h00, valid: 1'b0, last: 1'b1};
        canon_q = {canon_q, tail};
      end else begin
        canon_q[canon_q.size() - 1].last = 1'b1;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker and predictor feed, both on the rising edge. Inputs change
  // only at the falling edge, so every value read here is settled.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    canon_beat_t want;
    in_beat_seen = rst_n && push && !full;
    if (rst_n && pop && !empty) begin
      if (canon_q.size() == 0) begin
        report_mismatch("unexpected beat, out_byte", out_byte, 8'h00);
      end else begin
        want = canon_q.pop_front();
        if (out_byte !== want.data) begin
          report_mismatch("out_byte", out_byte, want.data);
        end
        if (out_valid !== want.valid) begin
          report_mismatch("out_valid", {7'd0, out_valid}, {7'd0, want.valid});
        end
        if (out_end !== want.last) begin
          report_mismatch("out_end", {7'd0, out_end}, {7'd0, want.last});
        end
      end
    end
    // An output beat is never caused by an input taken at the same edge, so
    // checking before predicting loses nothing.
    if (in_beat_seen) begin
      canon_step(in_byte, in_end_of_string);
    end
  end

  // ---------------------------------------------------------------------------
  // Byte feeder and receiver, both on the falling edge. A byte stays on the
  // input until it is taken; only then may the feeder idle or move on.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : byte_feed
    raw_byte_t nxt;
    if (!rst_n) begin
      push <= 1'b0;
    end else if (!push || in_beat_seen) begin
      if (byte_feed_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = byte_feed_q.pop_front();
        push             <= 1'b1;
        in_byte          <= nxt.data;
        in_end_of_string <= nxt.last;
      end else begin
        push <= 1'b0;
      end
    end
    pop <= rst_n && !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  function automatic void add_byte(input logic [7:0] b, input logic last);
    raw_byte_t rb;
    rb = '{data: b, last: last};
    byte_feed_q = {byte_feed_q, rb};
  endfunction

  function automatic void send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      add_byte(s[i], i == s.len() - 1);
    end
  endfunction

  function automatic logic [7:0] rand_hex_digit();
    string digits;
    digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(0, 21)];
  endfunction

  // Mostly well-formed text: escapes, plus signs, whitespace controls and
  // printable ASCII, with stray percent signs and arbitrary bytes mixed in.
  // Lengths are mostly short so that strings often end with a part-full window.
  task automatic queue_random_string(output int count);
    logic [7:0] text[$];
    int         len;
    int         r;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 8);
    while (text.size() < len) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        text = {text, CH_PERCENT};
        text = {text, rand_hex_digit()};
        text = {text, rand_hex_digit()};
      end else if (r < 20) begin
        text = {text, CH_PERCENT};
      end else if (r < 30) begin
        text = {text, CH_PLUS};
      end else if (r < 40) begin
        case ($urandom_range(0, 3))
          0: text = {text, CH_TAB};
          1: text = {text, CH_LF};
          2: text = {text, CH_FF};
          default: text = {text, CH_CR};
        endcase
      end else if (r < 55) begin
        text = {text, rand_hex_digit()};
      end else if (r < 75) begin
        text = {text, 8'($urandom_range(32, 126))};
      end else begin
        text = {text, 8'($urandom_range(0, 255))};
      end
    end
    for (int i = 0; i < text.size(); i++) begin
      add_byte(text[i], i == text.size() - 1);
    end
    count = text.size();
  endtask

  // Writes one register at a falling edge and updates the predictor's copy.
  // Only bit 0 of a flag register counts; the rest of the data is ignored.
  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MASK_LOW:    m_mask_lo = value;
      REG_MASK_HIGH:   m_mask_hi = value;
      REG_ALREADY_ENC: m_already = value[0];
      REG_STRICT_ESC:  m_strict  = value[0];
      REG_PLUS_SPACE:  m_plus    = value[0];
      REG_ASCII_ONLY:  m_ascii   = value[0];
      default: ;
    endcase
  endtask

  // Flag write with random junk above bit 0.
  task automatic cfg_flag(input logic [2:0] idx, input logic v);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    junk[0] = v;
    cfg_write(idx, junk);
  endtask

  function automatic logic [63:0] pick_mask();
    case ($urandom_range(0, 3))
      0: return 64'd0;
      1: return '1;
      2: return {$urandom, $urandom};
      default: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
    endcase
  endfunction

  // Waits until every queued byte has been taken and every predicted beat has
  // come back. Strings always close with an end mark, so the window is empty
  // by then; a settling wait follows so the block is quiet before a register write.
  task automatic drain();
    while (byte_feed_q.size() != 0 || push || canon_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int got;
    int seg_bytes;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = REG_MASK_LOW;
    cfg_data         = 64'd0;
    push             = 1'b0;
    in_byte          = 8'h00;
    in_end_of_string = 1'b0;
    pop              = 1'b0;
    hold_off         = 1'b0;
    in_beat_seen     = 1'b0;
    mismatch_count   = 0;
    win_cnt          = 0;
    win[0]           = 8'h00;
    win[1]           = 8'h00;
    m_mask_lo        = 64'd0;
    m_mask_hi        = 64'd0;
    m_already        = 1'b0;
    m_strict         = 1'b0;
    m_plus           = 1'b0;
    m_ascii          = 1'b0;
    send_idle_pct    = 11;
    recv_stall_pct   = 75;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed, reset configuration: control bytes, space, DEL, both ends of
    // the high range, a bare percent and a plus that is not special here.
    add_byte(8'h00, 1'b0);
    add_byte(8'h1f, 1'b0);
    add_byte(CH_SPACE, 1'b0);
    add_byte(CH_DEL, 1'b0);
    add_byte(CH_HIGH, 1'b0);
    add_byte(8'hff, 1'b0);
    add_byte(CH_PERCENT, 1'b0);
    add_byte(CH_PLUS, 1'b0);
    add_byte("~", 1'b1);
    // A one-byte string: the end mark arrives with the window empty.
    add_byte("z", 1'b1);
    drain();

    // Directed, already-encoded input with strict escapes and plus-as-space:
    // a valid escape is kept, a broken one is encoded, plus passes through,
    // whitespace controls vanish, and a percent near the end sees too little.
    cfg_flag(REG_ALREADY_ENC, 1'b1);
    cfg_flag(REG_STRICT_ESC, 1'b1);
    cfg_flag(REG_PLUS_SPACE, 1'b1);
    send_text("%4f%g1+");
    // Only dropped bytes: the string closes with a lone end marker.
    add_byte(CH_TAB, 1'b0);
    add_byte(CH_LF, 1'b0);
    add_byte(CH_FF, 1'b0);
    add_byte(CH_CR, 1'b1);
    send_text("%A");
    drain();

    // Random segments. The first two idle the sender lightly and stall the
    // receiver heavily, the next two the other way round, the last two not at
    // all. The first segment uses every register at its top value, the second
    // every register at zero, the rest random settings.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      send_idle_pct  = (seg < 2) ? 11 : (seg < 4) ? 75 : 0;
      recv_stall_pct = (seg < 2) ? 75 : (seg < 4) ? 11 : 0;
      if (seg == 0) begin
        cfg_write(REG_MASK_LOW, '1);
        cfg_write(REG_MASK_HIGH, '1);
        cfg_flag(REG_ALREADY_ENC, 1'b1);
        cfg_flag(REG_STRICT_ESC, 1'b1);
        cfg_flag(REG_PLUS_SPACE, 1'b1);
        cfg_flag(REG_ASCII_ONLY, 1'b1);
      end else if (seg == 1) begin
        cfg_write(REG_MASK_LOW, 64'd0);
        cfg_write(REG_MASK_HIGH, 64'd0);
        cfg_flag(REG_ALREADY_ENC, 1'b0);
        cfg_flag(REG_STRICT_ESC, 1'b0);
        cfg_flag(REG_PLUS_SPACE, 1'b0);
        cfg_flag(REG_ASCII_ONLY, 1'b0);
      end else begin
        cfg_write(REG_MASK_LOW, pick_mask());
        cfg_write(REG_MASK_HIGH, pick_mask());
        cfg_flag(REG_ALREADY_ENC, 1'($urandom_range(0, 1)));
        cfg_flag(REG_STRICT_ESC, 1'($urandom_range(0, 1)));
        cfg_flag(REG_PLUS_SPACE, 1'($urandom_range(0, 1)));
        cfg_flag(REG_ASCII_ONLY, 1'($urandom_range(0, 1)));
      end
      if (seg == 2) begin
        // Writes to unused indexes must leave every register alone.
        cfg_write(REG_SPARE_6, {$urandom, $urandom});
        cfg_write(REG_SPARE_7, {$urandom, $urandom});
      end
      if (seg == 4) begin
        // The receiver holds off for a long stretch while the sender keeps
        // offering bytes, so the block fills up and raises full.
        fork
          begin
            @(posedge clk);
            hold_off = 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      seg_bytes = 0;
      while (seg_bytes < SEGMENT_BYTES) begin
        queue_random_string(got);
        seg_bytes += got;
      end
      drain();
    end

    if (mismatch_count == 0) begin
      $display("url_percent_encoder_unit_tb passed");
    end else begin
      $display("url_percent_encoder_unit_tb failed");
    end
    $finish;
  end

endmodule
